// ===== rtl/core/adcss_pkg.sv =====
// Shared types and constants for the converter scan and color sequencer.
// No dependencies; imported by every module in rtl/core.

package adcss_pkg;

  // input actions (carried on in_tuser)
  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_SINGLE   = 3'd1;
  localparam logic [2:0] ACT_SCAN     = 3'd2;
  localparam logic [2:0] ACT_RD_CH    = 3'd3;
  localparam logic [2:0] ACT_RD_COLOR = 3'd4;

  // result kinds (carried on out_tuser)
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_MV    = 2'd1;
  localparam logic [1:0] KIND_COLOR = 2'd2;

  // poll interval codes
  localparam logic [1:0] IVL_SLOW  = 2'd0;
  localparam logic [1:0] IVL_FAST  = 2'd1;
  localparam logic [1:0] IVL_COLOR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_COLOR_MASK = 2'd0;
  localparam logic [1:0] REG_DEV_COUNT  = 2'd1;
  localparam logic [1:0] REG_CHAN_MAP   = 2'd2;

  // converter commands
  localparam logic [15:0] CMD_MANUAL_BASE = 16'h1840;
  localparam logic [15:0] CMD_AUTO        = 16'h2840;

  // millivolt conversion
  localparam int unsigned REF_UV    = 2500000;
  localparam int unsigned UV_PER_MV = 1000;
  localparam int unsigned MV_SHIFT  = 24;

  localparam int unsigned VALUE_W   = 13;
  localparam int unsigned COL_SLOTS = 16;

  typedef struct packed {
    logic        cmd_issued;
    logic [15:0] command_word;
    logic        use_scan;
    logic [1:0]  interval_select;
  } seq_tick_t;

  typedef struct packed {
    logic       ch_we;
    logic [3:0] ch_addr;
    logic       col_we;
    logic [3:0] col_addr;
  } store_wr_t;

endpackage

// ===== rtl/core/adcss_seq.sv =====
// Sequencer state: configuration registers, port and color step counters,
// busy/stopped flags, tick command decision. Depends on adcss_pkg.

module adcss_seq import adcss_pkg::*; #(
  parameter int PORTS       = 4,
  parameter int COLOR_STEPS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        fire,
  input  logic [2:0]  action,
  input  logic [15:0] rx_word,
  input  logic        xfer_error,
  input  logic        last_word,
  output seq_tick_t   tick,
  output store_wr_t   wr
);

  localparam int PORT_W = (PORTS > 1) ? $clog2(PORTS) : 1;

  logic [3:0]        mask_r;
  logic [7:0]        count_r;
  logic [15:0]       map_r;
  logic [PORT_W-1:0] port_r, port_nxt, port_adv;
  logic [1:0]        step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              auto_r, auto_nxt;
  logic              stop_r, stop_nxt;
  logic [4:0]        port_ext;
  logic              is_color;
  logic [3:0]        port_ch;
  logic              manual;
  logic              last_step;
  logic [3:0]        scan_ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      count_r <= '0;
      map_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COLOR_MASK: mask_r  <= cfg_wdata[3:0];
        REG_DEV_COUNT:  count_r <= cfg_wdata[7:0];
        REG_CHAN_MAP:   map_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r <= '0;
      step_r <= '0;
      busy_r <= 1'b0;
      auto_r <= 1'b0;
      stop_r <= 1'b0;
    end else begin
      port_r <= port_nxt;
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      auto_r <= auto_nxt;
      stop_r <= stop_nxt;
    end
  end

  always_comb begin
    port_ext  = 5'(port_r);
    is_color  = (port_ext < 5'd4) && mask_r[port_ext[1:0]];
    port_ch   = (port_ext < 5'd4) ? map_r[{port_ext[1:0], 2'b00} +: 4] : 4'd0;
    port_adv  = (port_r == PORT_W'(PORTS - 1)) ? '0 : port_r + PORT_W'(1);
    last_step = (step_r == 2'(COLOR_STEPS - 1));
    manual    = is_color && !last_step;
    scan_ch   = rx_word[15:12];

    tick.cmd_issued   = !busy_r && !stop_r;
    tick.command_word = manual ? (CMD_MANUAL_BASE | {5'd0, port_ch, 7'd0}) : CMD_AUTO;
    tick.use_scan     = auto_r;
    if (count_r == 8'd0) begin
      tick.interval_select = IVL_SLOW;
    end else if (is_color) begin
      tick.interval_select = IVL_COLOR;
    end else begin
      tick.interval_select = IVL_FAST;
    end

    port_nxt = port_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    auto_nxt = auto_r;
    stop_nxt = stop_r;
    wr       = '0;

    if (fire) begin
      case (action)
        ACT_TICK: begin
          if (!busy_r && !stop_r) begin
            auto_nxt = !manual;
            busy_nxt = 1'b1;
          end
        end
        ACT_SINGLE: begin
          if (xfer_error) begin
            stop_nxt = 1'b1;
          end else if (is_color) begin
            wr.col_we   = 1'b1;
            wr.col_addr = {port_ext[1:0], step_r};
            if (last_step) begin
              step_nxt = '0;
              port_nxt = port_adv;
            end else begin
              step_nxt = step_r + 2'd1;
            end
          end
          busy_nxt = 1'b0;
        end
        ACT_SCAN: begin
          if (xfer_error) begin
            stop_nxt = 1'b1;
          end else begin
            wr.ch_we   = 1'b1;
            wr.ch_addr = scan_ch;
            if (last_word && !is_color) begin
              port_nxt = port_adv;
              step_nxt = '0;
            end
          end
          if (last_word) begin
            busy_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/adcss_store.sv =====
// Channel and color sample stores with read-side millivolt scaling.
// Depends on adcss_pkg; write controls come from adcss_seq.

module adcss_store import adcss_pkg::*; #(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  store_wr_t          wr,
  input  logic [15:0]        rx_word,
  input  logic [3:0]         rd_idx,
  output logic [VALUE_W-1:0] ch_mv,
  output logic [VALUE_W-1:0] col_sample
);

  localparam int CH_W = $clog2(CHANNELS);
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned LSB_UV = (2 * REF_UV) / SAMPLE_MAX;
  localparam longint unsigned MV_K =
    ((longint'(LSB_UV) << MV_SHIFT) + longint'(UV_PER_MV - 1)) / longint'(UV_PER_MV);
  localparam int PROD_W = SAMPLE_BITS + 32;

  logic [SAMPLE_BITS-1:0] ch_mem  [CHANNELS];
  logic [SAMPLE_BITS-1:0] col_mem [COL_SLOTS];
  logic [SAMPLE_BITS-1:0] ch_rd;
  logic [SAMPLE_BITS-1:0] sample;
  logic [PROD_W-1:0]      prod;

  assign sample = rx_word[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ch_mem[i] <= '0;
      end
      for (int i = 0; i < COL_SLOTS; i++) begin
        col_mem[i] <= '0;
      end
    end else if (fire) begin
      if (wr.ch_we && (5'(wr.ch_addr) < 5'(CHANNELS))) begin
        ch_mem[wr.ch_addr[CH_W-1:0]] <= sample;
      end
      if (wr.col_we) begin
        col_mem[wr.col_addr] <= sample;
      end
    end
  end

  // mv = sample * LSB_UV / 1000, via a scaled reciprocal
  always_comb begin
    ch_rd      = ch_mem[rd_idx[CH_W-1:0]];
    prod       = PROD_W'(ch_rd) * PROD_W'(32'(MV_K));
    ch_mv      = prod[MV_SHIFT +: VALUE_W];
    col_sample = VALUE_W'(col_mem[rd_idx]);
  end

endmodule

// ===== rtl/core/adc_scan_color_sequencer.sv =====
// Top level of the converter scan and color sequencer: stream handshake,
// input and result registers. Depends on adcss_pkg, adcss_seq, adcss_store.
//
// Usage:
//   in_*  : one transaction per action; in_tuser is the action, in_tlast
//           marks the final word of a scan, in_tdata carries the word,
//           the transfer error flag and the read index.
//   out_* : tick reports and read results; out_tuser is the result kind.
//           Single-done and scan-word transactions, reads out of range and
//           unknown actions produce no result.
//   cfg_* : register writes, taken on any edge with cfg_wr_en high; write
//           only while no transaction is in flight.
// Path: a result passes through the input register, loaded when its input is
//   accepted, and then the result register, loaded when the input moves on.
//   Throughput: one transaction per cycle unless out_tready stalls the result
//   register; counters and stores update as each transaction moves on.
// Reset (synchronous, rst_n low) clears config registers, valid flags,
//   counters, flags and both sample stores; no clearing pass is needed.
// Stall: when out_tready is low the result register holds; one more input
//   is absorbed in the input register before in_tready drops.

module adc_scan_color_sequencer import adcss_pkg::*; #(
  parameter int CHANNELS    = 16,
  parameter int PORTS       = 4,
  parameter int COLOR_STEPS = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // rx_word[15:0], xfer_error[16], index[20:17], zero pad
  input  logic [2:0]  in_tuser,   // action
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // cmd_issued[0], command_word[16:1], use_scan[17],
                                  // interval_select[19:18], value[32:20], zero pad
  output logic [1:0]  out_tuser,  // result_kind
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic               in_valid_r, in_valid_nxt;
  logic [2:0]         act_r;
  logic [15:0]        rx_r;
  logic               err_r;
  logic               last_r;
  logic [3:0]         idx_r;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [32:0]        data_r, data_nxt;
  logic               in_acc;
  logic               has_res;
  logic               out_free;
  logic               move;
  seq_tick_t          tick;
  store_wr_t          wr;
  logic [VALUE_W-1:0] ch_mv;
  logic [VALUE_W-1:0] col_sample;

  adcss_seq #(
    .PORTS       (PORTS),
    .COLOR_STEPS (COLOR_STEPS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fire       (move),
    .action     (act_r),
    .rx_word    (rx_r),
    .xfer_error (err_r),
    .last_word  (last_r),
    .tick       (tick),
    .wr         (wr)
  );

  adcss_store #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (move),
    .wr         (wr),
    .rx_word    (rx_r),
    .rd_idx     (idx_r),
    .ch_mv      (ch_mv),
    .col_sample (col_sample)
  );

  always_comb begin
    case (act_r)
      ACT_TICK:     has_res = 1'b1;
      ACT_RD_CH:    has_res = (5'(idx_r) < 5'(CHANNELS));
      ACT_RD_COLOR: has_res = (5'(idx_r[3:2]) < 5'(PORTS)) &&
                              (3'(idx_r[1:0]) < 3'(COLOR_STEPS));
      default:      has_res = 1'b0;
    endcase

    out_free     = !out_valid_r || out_tready;
    move         = in_valid_r && (!has_res || out_free);
    in_tready    = !in_valid_r || move;
    in_acc       = in_tvalid && in_tready;
    in_valid_nxt = in_acc ? 1'b1 : (move ? 1'b0 : in_valid_r);

    kind_nxt = kind_r;
    data_nxt = data_r;
    if (move && has_res) begin
      out_valid_nxt = 1'b1;
      case (act_r)
        ACT_TICK: begin
          kind_nxt = KIND_TICK;
          if (tick.cmd_issued) begin
            data_nxt = {VALUE_W'(0), tick.interval_select, tick.use_scan,
                        tick.command_word, 1'b1};
          end else begin
            data_nxt = {VALUE_W'(0), tick.interval_select, 18'd0};
          end
        end
        ACT_RD_CH: begin
          kind_nxt = KIND_MV;
          data_nxt = {ch_mv, 20'd0};
        end
        default: begin
          kind_nxt = KIND_COLOR;
          data_nxt = {col_sample, 20'd0};
        end
      endcase
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_tuser;
      rx_r   <= in_tdata[15:0];
      err_r  <= in_tdata[16];
      idx_r  <= in_tdata[20:17];
      last_r <= in_tlast;
    end
    kind_r <= kind_nxt;
    data_r <= data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {7'd0, data_r};

endmodule
